@@ hw/rtl/iframe_receiver_destuff_check_assert.svh @@
// Assertion macros for the frame receiver.
// Each macro checks an implication under an active-low reset.
`ifndef IFRAME_RECEIVER_DESTUFF_CHECK_ASSERT_SVH
`define IFRAME_RECEIVER_DESTUFF_CHECK_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define IFDR_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication
`define IFDR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define IFDR_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define IFDR_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ hw/rtl/ifdr_pkg.sv @@
`default_nettype none

package ifdr_pkg;

  // Field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 11;
  localparam int unsigned VerdictW = 2;

  // Line framing bytes
  localparam logic [ByteW-1:0] FlagByte  = 8'h7E;
  localparam logic [ByteW-1:0] EscByte   = 8'h7D;
  localparam logic [ByteW-1:0] EscMask   = 8'h20;
  localparam logic [ByteW-1:0] AddrByte  = 8'h03;
  localparam logic [ByteW-1:0] Ctrl0Byte = 8'h00;
  localparam logic [ByteW-1:0] Ctrl1Byte = 8'h80;

  // Supervision reply control bytes
  localparam logic [ByteW-1:0] ReplyRr0  = 8'hAA;
  localparam logic [ByteW-1:0] ReplyRr1  = 8'hAB;
  localparam logic [ByteW-1:0] ReplyRej0 = 8'h54;
  localparam logic [ByteW-1:0] ReplyRej1 = 8'h55;
  localparam logic [ByteW-1:0] ReplyNone = 8'h00;

  // End-of-frame verdicts
  typedef enum logic [VerdictW-1:0] {
    VerdAccepted  = 2'd0,
    VerdDuplicate = 2'd1,
    VerdBccError  = 2'd2,
    VerdLenError  = 2'd3
  } verdict_e;

endpackage

`default_nettype wire

@@ hw/rtl/ifdr_intf.sv @@
`default_nettype none

// Line byte channel
interface ifdr_line_if;
  logic                         valid;
  logic                         ready;
  logic [ifdr_pkg::ByteW-1:0]   line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink   (input valid, input line_byte, output ready);
endinterface

// Result channel
interface ifdr_result_if;
  logic                          valid;
  logic                          ready;
  logic                          frame_end;
  logic [ifdr_pkg::ByteW-1:0]    payload_byte;
  logic [ifdr_pkg::VerdictW-1:0] verdict;
  logic [ifdr_pkg::ByteW-1:0]    reply_control;
  logic [ifdr_pkg::LenW-1:0]     payload_length;

  modport source (output valid, output frame_end, output payload_byte, output verdict,
                  output reply_control, output payload_length, input ready);
  modport sink   (input valid, input frame_end, input payload_byte, input verdict,
                  input reply_control, input payload_length, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/iframe_receiver_destuff_check.sv @@
// Byte-stuffed I-frame receiver. Takes one line byte per word on line_i and
// gives at most one word on result_o per line byte: a destuffed payload byte
// (frame_end 0) or an end-of-frame verdict with the supervision reply byte
// (frame_end 1). The last destuffed byte of a frame is held back as BCC2, so
// payload words lag the line by one data byte. A new line byte is taken every
// cycle while result_o is ready; each byte goes from the input register into
// the output register. The frame state machine plus the output register set
// that rate; a stalled result_o holds the input register and then line_i.
// Payload words of a rejected frame are still emitted and must be dropped
// by the consumer on a verdict of 2 or 3.
`default_nettype none

`include "iframe_receiver_destuff_check_assert.svh"

module iframe_receiver_destuff_check #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ifdr_line_if.sink       line_i,
  ifdr_result_if.source   result_o
);

  // Byte counter holds up to MAX_PAYLOAD + 1 and is at least the port width
  localparam int unsigned NeedW = $clog2(MAX_PAYLOAD + 2);
  localparam int unsigned CntW  = (NeedW > ifdr_pkg::LenW) ? NeedW : ifdr_pkg::LenW;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PAYLOAD);

  typedef enum logic [4:0] {
    PhHunt = 5'b00001,
    PhFlag = 5'b00010,
    PhAddr = 5'b00100,
    PhCtrl = 5'b01000,
    PhData = 5'b10000
  } phase_e;

  // Input register
  logic                       in_valid_q;
  logic [ifdr_pkg::ByteW-1:0] in_byte_q;

  // Frame state
  phase_e                     phase_q, phase_d;
  logic                       ctrl_q, ctrl_d;
  logic                       esc_q, esc_d;
  logic [ifdr_pkg::ByteW-1:0] held_q, held_d;
  logic                       held_valid_q, held_valid_d;
  logic [ifdr_pkg::ByteW-1:0] xor_q, xor_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       seq_q, seq_d;

  // Output register
  logic                          out_valid_q;
  logic                          out_end_q, out_end_d;
  logic [ifdr_pkg::ByteW-1:0]    out_byte_q, out_byte_d;
  ifdr_pkg::verdict_e            out_verd_q, out_verd_d;
  logic [ifdr_pkg::ByteW-1:0]    out_reply_q, out_reply_d;
  logic [ifdr_pkg::LenW-1:0]     out_len_q, out_len_d;
  logic                          emit;

  logic                       out_free;
  logic                       step;
  logic [ifdr_pkg::ByteW-1:0] data_byte;
  ifdr_pkg::verdict_e         verd;

  // Handshake: input register moves on when the output register can take a word
  assign out_free     = !out_valid_q || result_o.ready;
  assign step         = in_valid_q && out_free;
  assign line_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (line_i.ready) begin
      in_valid_q <= line_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (line_i.valid && line_i.ready) begin
      in_byte_q <= line_i.line_byte;
    end
  end

  // Destuffed value of the current byte
  assign data_byte = esc_q ? (in_byte_q ^ ifdr_pkg::EscMask) : in_byte_q;

  // Verdict at the closing flag: length error over check error over sequence
  always_comb begin
    if (esc_q || !held_valid_q || (cnt_q > MaxCnt)) begin
      verd = ifdr_pkg::VerdLenError;
    end else if (xor_q != held_q) begin
      verd = ifdr_pkg::VerdBccError;
    end else if (ctrl_q == seq_q) begin
      verd = ifdr_pkg::VerdDuplicate;
    end else begin
      verd = ifdr_pkg::VerdAccepted;
    end
  end

  // Frame state machine and result formation
  always_comb begin
    phase_d      = phase_q;
    ctrl_d       = ctrl_q;
    esc_d        = esc_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    xor_d        = xor_q;
    cnt_d        = cnt_q;
    seq_d        = seq_q;
    emit         = 1'b0;
    out_end_d    = 1'b0;
    out_byte_d   = '0;
    out_verd_d   = ifdr_pkg::VerdAccepted;
    out_reply_d  = ifdr_pkg::ReplyNone;
    out_len_d    = '0;

    if (step) begin
      case (phase_q)
        PhHunt: begin
          if (in_byte_q == ifdr_pkg::FlagByte) phase_d = PhFlag;
        end
        PhFlag: begin
          if (in_byte_q == ifdr_pkg::FlagByte) begin
            phase_d = PhFlag;
          end else if (in_byte_q == ifdr_pkg::AddrByte) begin
            phase_d = PhAddr;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhAddr: begin
          if (in_byte_q == ifdr_pkg::FlagByte) begin
            phase_d = PhFlag;
          end else if (in_byte_q == ifdr_pkg::Ctrl0Byte ||
                       in_byte_q == ifdr_pkg::Ctrl1Byte) begin
            ctrl_d  = in_byte_q[ifdr_pkg::ByteW-1];
            phase_d = PhCtrl;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhCtrl: begin
          if (in_byte_q == ifdr_pkg::FlagByte) begin
            phase_d = PhFlag;
          end else if (in_byte_q ==
                       (ifdr_pkg::AddrByte ^ {ctrl_q, {(ifdr_pkg::ByteW-1){1'b0}}})) begin
            // BCC1 good: start a clean data section
            esc_d        = 1'b0;
            held_d       = '0;
            held_valid_d = 1'b0;
            xor_d        = '0;
            cnt_d        = '0;
            phase_d      = PhData;
          end else begin
            phase_d = PhHunt;
          end
        end
        PhData: begin
          if (in_byte_q == ifdr_pkg::FlagByte) begin
            // Closing flag: verdict word
            emit       = 1'b1;
            out_end_d  = 1'b1;
            out_verd_d = verd;
            out_len_d  = cnt_q[ifdr_pkg::LenW-1:0];
            if (verd == ifdr_pkg::VerdAccepted || verd == ifdr_pkg::VerdDuplicate) begin
              out_reply_d = ctrl_q ? ifdr_pkg::ReplyRr0 : ifdr_pkg::ReplyRr1;
              seq_d       = ctrl_q;
            end else begin
              out_reply_d = seq_q ? ifdr_pkg::ReplyRej1 : ifdr_pkg::ReplyRej0;
            end
            esc_d        = 1'b0;
            held_d       = '0;
            held_valid_d = 1'b0;
            xor_d        = '0;
            cnt_d        = '0;
            phase_d      = PhHunt;
          end else if (!esc_q && in_byte_q == ifdr_pkg::EscByte) begin
            esc_d = 1'b1;
          end else begin
            // Data byte: release the held one as payload
            esc_d = 1'b0;
            if (held_valid_q) begin
              xor_d = xor_q ^ held_q;
              if (cnt_q <= MaxCnt) cnt_d = cnt_q + 1'b1;
              emit       = 1'b1;
              out_byte_d = held_q;
              out_len_d  = cnt_d[ifdr_pkg::LenW-1:0];
            end
            held_d       = data_byte;
            held_valid_d = 1'b1;
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhHunt;
      ctrl_q       <= 1'b0;
      esc_q        <= 1'b0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      xor_q        <= '0;
      cnt_q        <= '0;
      seq_q        <= 1'b1;
    end else begin
      phase_q      <= phase_d;
      ctrl_q       <= ctrl_d;
      esc_q        <= esc_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      xor_q        <= xor_d;
      cnt_q        <= cnt_d;
      seq_q        <= seq_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_end_q   <= out_end_d;
      out_byte_q  <= out_byte_d;
      out_verd_q  <= out_verd_d;
      out_reply_q <= out_reply_d;
      out_len_q   <= out_len_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.frame_end      = out_end_q;
  assign result_o.payload_byte   = out_byte_q;
  assign result_o.verdict        = out_verd_q;
  assign result_o.reply_control  = out_reply_q;
  assign result_o.payload_length = out_len_q;

  // Checks
  `IFDR_ASSERT_IMPL(a_esc_in_data, clk_i, rst_ni, esc_q, phase_q == PhData)
  `IFDR_ASSERT_IMPL(a_empty_cnt_zero, clk_i, rst_ni, !held_valid_q, cnt_q == '0)
  `IFDR_ASSERT_NEXT(a_flag_ends_frame, clk_i, rst_ni,
                    step && phase_q == PhData && in_byte_q == ifdr_pkg::FlagByte,
                    phase_q == PhHunt && out_valid_q && out_end_q)
  `IFDR_ASSERT_IMPL(a_payload_word_clean, clk_i, rst_ni, out_valid_q && !out_end_q,
                    out_verd_q == ifdr_pkg::VerdAccepted &&
                    out_reply_q == ifdr_pkg::ReplyNone)

endmodule

`default_nettype wire

@@ verif/iframe_receiver_destuff_check_tb.sv @@
`default_nettype none

module iframe_receiver_destuff_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPayload = 1024;
  localparam time         RunLimit   = 5_000_000;

  typedef logic [ifdr_pkg::ByteW-1:0] byte_t;
  typedef logic [ifdr_pkg::LenW-1:0]  len_t;

  // Frame phases of the predictor
  typedef enum logic [2:0] {
    PhHunt,
    PhFlag,
    PhAddr,
    PhCtrl,
    PhData
  } line_phase_e;

  // How a generated frame ends
  typedef enum int {
    TailGood,
    TailBadBcc,
    TailNoBcc,
    TailDangling
  } frame_tail_e;

  // One result word as the block should give it
  typedef struct {
    logic                frame_end;
    byte_t               payload_byte;
    ifdr_pkg::verdict_e  verdict;
    byte_t               reply_control;
    len_t                payload_length;
  } result_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ifdr_line_if   line_if ();
  ifdr_result_if result_if ();

  iframe_receiver_destuff_check #(
    .MAX_PAYLOAD(MaxPayload)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .line_i  (line_if),
    .result_o(result_if)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  line_phase_e rx_phase;
  logic        rx_seq;
  logic        rx_escape;
  byte_t       rx_held;
  logic        rx_held_ok;
  byte_t       rx_xor;
  len_t        rx_count;
  logic        rx_last_seq;

  result_word_t expected_words[$];
  result_word_t next_expected;

  int send_idle_pct;
  int stall_pct;
  int hold_request;
  int hold_left;
  int line_words_sent;
  int mismatch_count;

  function automatic void clear_frame_data();
    rx_escape  = 1'b0;
    rx_held    = '0;
    rx_held_ok = 1'b0;
    rx_xor     = '0;
    rx_count   = '0;
  endfunction

  function automatic void reset_receiver_model();
    rx_phase    = PhHunt;
    rx_seq      = 1'b0;
    rx_last_seq = 1'b1;
    clear_frame_data();
  endfunction

  // Work out what one accepted line byte causes
  function automatic void predict_line_byte(byte_t b);
    result_word_t w;
    byte_t        d;
    w.frame_end      = 1'b0;
    w.payload_byte   = '0;
    w.verdict        = ifdr_pkg::VerdAccepted;
    w.reply_control  = ifdr_pkg::ReplyNone;
    w.payload_length = '0;
    case (rx_phase)
      PhHunt: begin
        if (b == ifdr_pkg::FlagByte) rx_phase = PhFlag;
      end
      PhFlag: begin
        if (b == ifdr_pkg::FlagByte) rx_phase = PhFlag;
        else if (b == ifdr_pkg::AddrByte) rx_phase = PhAddr;
        else rx_phase = PhHunt;
      end
      PhAddr: begin
        if (b == ifdr_pkg::FlagByte) begin
          rx_phase = PhFlag;
        end else if (b == ifdr_pkg::Ctrl0Byte || b == ifdr_pkg::Ctrl1Byte) begin
          rx_seq   = b[7];
          rx_phase = PhCtrl;
        end else begin
          rx_phase = PhHunt;
        end
      end
      PhCtrl: begin
        if (b == ifdr_pkg::FlagByte) begin
          rx_phase = PhFlag;
        end else if (b == (ifdr_pkg::AddrByte ^
                           (rx_seq ? ifdr_pkg::Ctrl1Byte : ifdr_pkg::Ctrl0Byte))) begin
          clear_frame_data();
          rx_phase = PhData;
        end else begin
          rx_phase = PhHunt;
        end
      end
      PhData: begin
        if (b == ifdr_pkg::FlagByte) begin
          // closing flag: escape, length and empty errors first, then BCC2, then sequence
          if (rx_escape || !rx_held_ok || rx_count > MaxPayload)
            w.verdict = ifdr_pkg::VerdLenError;
          else if (rx_xor != rx_held) w.verdict = ifdr_pkg::VerdBccError;
          else if (rx_seq == rx_last_seq) w.verdict = ifdr_pkg::VerdDuplicate;
          else w.verdict = ifdr_pkg::VerdAccepted;
          if (w.verdict == ifdr_pkg::VerdAccepted || w.verdict == ifdr_pkg::VerdDuplicate) begin
            w.reply_control = rx_seq ? ifdr_pkg::ReplyRr0 : ifdr_pkg::ReplyRr1;
            rx_last_seq     = rx_seq;
          end else begin
            w.reply_control = rx_last_seq ? ifdr_pkg::ReplyRej1 : ifdr_pkg::ReplyRej0;
          end
          w.frame_end      = 1'b1;
          w.payload_length = rx_count;
          expected_words.push_back(w);
          clear_frame_data();
          rx_phase = PhHunt;
        end else if (!rx_escape && b == ifdr_pkg::EscByte) begin
          rx_escape = 1'b1;
        end else begin
          d         = rx_escape ? (b ^ ifdr_pkg::EscMask) : b;
          rx_escape = 1'b0;
          // the byte held so far was not BCC2 after all
          if (rx_held_ok) begin
            rx_xor = rx_xor ^ rx_held;
            if (rx_count <= MaxPayload) rx_count = rx_count + 1'b1;
            w.payload_byte   = rx_held;
            w.payload_length = rx_count;
            expected_words.push_back(w);
          end
          rx_held    = d;
          rx_held_ok = 1'b1;
        end
      end
      default: rx_phase = PhHunt;
    endcase
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_words.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected word: end %0b byte %02h verdict %0d reply %02h len %0d",
                   $realtime, result_if.frame_end, result_if.payload_byte, result_if.verdict,
                   result_if.reply_control, result_if.payload_length);
        mismatch_count++;
      end else begin
        next_expected = expected_words.pop_front();
        if (result_if.frame_end !== next_expected.frame_end
            || result_if.payload_byte !== next_expected.payload_byte
            || result_if.verdict !== next_expected.verdict
            || result_if.reply_control !== next_expected.reply_control
            || result_if.payload_length !== next_expected.payload_length) begin
          if (mismatch_count < 10) begin
            $display("%0t: mismatch: expected end %0b byte %02h verdict %0d reply %02h len %0d",
                     $realtime, next_expected.frame_end, next_expected.payload_byte,
                     next_expected.verdict, next_expected.reply_control,
                     next_expected.payload_length);
            $display("%0t:           actual end %0b byte %02h verdict %0d reply %02h len %0d",
                     $realtime, result_if.frame_end, result_if.payload_byte, result_if.verdict,
                     result_if.reply_control, result_if.payload_length);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Result ready: random stalls, or a long hold-off when one is requested
  initial begin
    result_if.ready <= 1'b0;
    hold_left       = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Run limit
  initial begin
    #RunLimit;
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one line byte, with random gaps before it, and wait for it to be taken
  task automatic send_line_byte(input byte_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      line_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    line_if.valid     <= 1'b1;
    line_if.line_byte <= b;
    @(posedge clk_i);
    while (!line_if.ready) @(posedge clk_i);
    predict_line_byte(b);
    line_words_sent++;
  endtask

  task automatic send_bytes(input byte_t line_bytes[$]);
    foreach (line_bytes[i]) send_line_byte(line_bytes[i]);
  endtask

  // Data byte with escaping of flag and escape values
  task automatic send_stuffed(input byte_t d);
    if (d == ifdr_pkg::FlagByte || d == ifdr_pkg::EscByte) begin
      send_line_byte(ifdr_pkg::EscByte);
      send_line_byte(d ^ ifdr_pkg::EscMask);
    end else begin
      send_line_byte(d);
    end
  endtask

  task automatic send_frame(input logic seq, input byte_t payload[$],
                            input frame_tail_e tail, input int extra_flags);
    byte_t ctrl;
    byte_t bcc;
    ctrl = seq ? ifdr_pkg::Ctrl1Byte : ifdr_pkg::Ctrl0Byte;
    bcc  = '0;
    repeat (extra_flags + 1) send_line_byte(ifdr_pkg::FlagByte);
    send_line_byte(ifdr_pkg::AddrByte);
    send_line_byte(ctrl);
    send_line_byte(ifdr_pkg::AddrByte ^ ctrl);
    foreach (payload[i]) begin
      bcc = bcc ^ payload[i];
      send_stuffed(payload[i]);
    end
    case (tail)
      TailGood:     send_stuffed(bcc);
      TailBadBcc:   send_stuffed(bcc ^ (8'h01 << $urandom_range(7)));
      TailDangling: begin
        send_stuffed(bcc);
        send_line_byte(ifdr_pkg::EscByte);
      end
      default: ;
    endcase
    send_line_byte(ifdr_pkg::FlagByte);
  endtask

  // Random data byte, often a flag or escape value so stuffing gets exercised
  function automatic byte_t random_data_byte();
    case ($urandom_range(7))
      0:       return ifdr_pkg::FlagByte;
      1:       return ifdr_pkg::EscByte;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  // Drop valid and wait until every expected word is in, plus the pipeline latency
  task automatic wait_results_drained();
    int spins;
    spins = 0;
    line_if.valid <= 1'b0;
    while (expected_words.size() != 0 && spins < 50000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_idle_mix(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // Hunting, bad header bytes, flags inside the header, repeated flags
  task automatic test_header_hunting();
    byte_t seq_bytes[$];
    set_idle_mix(0, 0);
    // noise while hunting, then a flag followed by junk
    seq_bytes = '{8'h00, 8'hFF, ifdr_pkg::AddrByte, ifdr_pkg::FlagByte, 8'hFF};
    send_bytes(seq_bytes);
    // bad control byte, then bad BCC1
    seq_bytes = '{ifdr_pkg::FlagByte, ifdr_pkg::AddrByte, 8'h01, ifdr_pkg::FlagByte,
                  ifdr_pkg::AddrByte, ifdr_pkg::Ctrl0Byte, 8'h00};
    send_bytes(seq_bytes);
    // flag after address and after control restart the header; repeated flags absorbed
    seq_bytes = '{ifdr_pkg::FlagByte, ifdr_pkg::FlagByte, ifdr_pkg::FlagByte,
                  ifdr_pkg::AddrByte, ifdr_pkg::FlagByte, ifdr_pkg::AddrByte,
                  ifdr_pkg::Ctrl1Byte, ifdr_pkg::FlagByte, ifdr_pkg::AddrByte,
                  ifdr_pkg::Ctrl1Byte, ifdr_pkg::AddrByte ^ ifdr_pkg::Ctrl1Byte,
                  8'h42, 8'h42, ifdr_pkg::FlagByte};
    send_bytes(seq_bytes);
    // the closing flag must not open the next frame
    seq_bytes = '{ifdr_pkg::AddrByte, ifdr_pkg::Ctrl0Byte, ifdr_pkg::AddrByte,
                  8'h11, 8'h11, ifdr_pkg::FlagByte};
    send_bytes(seq_bytes);
    wait_results_drained();
  endtask

  // Destuffing of flag and escape values, escaped ordinary bytes, field extremes
  task automatic test_payload_destuffing();
    byte_t seq_bytes[$];
    byte_t payload[$];
    set_idle_mix(31, 31);
    payload = '{8'h00, 8'hFF, ifdr_pkg::FlagByte, ifdr_pkg::EscByte, 8'h41};
    send_frame(1'b0, payload, TailGood, 0);
    // escaped 0x41 reads as 0x61, and BCC2 is the same byte
    seq_bytes = '{ifdr_pkg::FlagByte, ifdr_pkg::AddrByte, ifdr_pkg::Ctrl1Byte,
                  ifdr_pkg::AddrByte ^ ifdr_pkg::Ctrl1Byte,
                  ifdr_pkg::EscByte, 8'h41, 8'h61, ifdr_pkg::FlagByte};
    send_bytes(seq_bytes);
    wait_results_drained();
  endtask

  // Every verdict and reply, sequence tracking, empty and dangling cases
  task automatic test_verdicts();
    byte_t seq_bytes[$];
    byte_t payload[$];
    set_idle_mix(0, 68);
    payload = '{8'h12, 8'h34};
    send_frame(1'b0, payload, TailGood, 0);
    send_frame(1'b0, payload, TailGood, 0);
    send_frame(1'b1, payload, TailBadBcc, 0);
    send_frame(1'b1, payload, TailGood, 0);
    send_frame(1'b1, payload, TailGood, 1);
    send_frame(1'b0, payload, TailBadBcc, 0);
    send_frame(1'b0, payload, TailDangling, 0);
    payload.delete();
    // header then flag: no data at all
    send_frame(1'b0, payload, TailNoBcc, 0);
    // only a BCC2 of zero
    send_frame(1'b0, payload, TailGood, 0);
    // only a nonzero BCC2
    seq_bytes = '{ifdr_pkg::FlagByte, ifdr_pkg::AddrByte, ifdr_pkg::Ctrl1Byte,
                  ifdr_pkg::AddrByte ^ ifdr_pkg::Ctrl1Byte, 8'h5A, ifdr_pkg::FlagByte};
    send_bytes(seq_bytes);
    // dangling escape outranks a BCC2 mismatch
    seq_bytes = '{ifdr_pkg::FlagByte, ifdr_pkg::AddrByte, ifdr_pkg::Ctrl0Byte,
                  ifdr_pkg::AddrByte, 8'h11, 8'h22, ifdr_pkg::EscByte, ifdr_pkg::FlagByte};
    send_bytes(seq_bytes);
    wait_results_drained();
  endtask

  // Payload at the limit, one over it, and a saturated count with a bad BCC2
  task automatic test_length_limit();
    byte_t payload[$];
    set_idle_mix(0, 0);
    payload.delete();
    repeat (MaxPayload) payload.push_back(byte_t'($urandom_range(255)));
    send_frame(1'b1, payload, TailGood, 0);
    payload.push_back(byte_t'($urandom_range(255)));
    send_frame(1'b0, payload, TailGood, 0);
    payload.push_back(byte_t'($urandom_range(255)));
    send_frame(1'b1, payload, TailBadBcc, 0);
    wait_results_drained();
  endtask

  // Long result hold-off while line bytes keep coming, then a full pause
  task automatic test_backpressure();
    byte_t payload[$];
    set_idle_mix(0, 0);
    payload.delete();
    repeat (40) payload.push_back(random_data_byte());
    hold_request = 300;
    send_frame(1'($urandom_range(1)), payload, TailGood, 0);
    wait_results_drained();
  endtask

  // Random frames: mostly well formed, some broken, some line noise
  task automatic test_random_frames();
    int    send_mix[4];
    int    recv_mix[4];
    int    target;
    int    pick;
    int    len;
    byte_t payload[$];
    send_mix = '{0, 68, 0, 31};
    recv_mix = '{0, 0, 68, 31};
    for (int p = 0; p < 4; p++) begin
      set_idle_mix(send_mix[p], recv_mix[p]);
      target = line_words_sent + 150;
      while (line_words_sent < target) begin
        pick = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        payload.delete();
        repeat (len) payload.push_back(random_data_byte());
        if (pick < 70) begin
          send_frame(1'($urandom_range(1)), payload, TailGood,
                     int'($urandom_range(3) == 0));
        end else if (pick < 80) begin
          send_frame(1'($urandom_range(1)), payload, TailBadBcc, 0);
        end else if (pick < 85) begin
          send_frame(1'($urandom_range(1)), payload, TailDangling, 0);
        end else if (pick < 90) begin
          send_frame(1'($urandom_range(1)), payload, TailNoBcc, 0);
        end else if (pick < 95) begin
          repeat ($urandom_range(1, 6)) send_line_byte(byte_t'($urandom_range(255)));
        end else begin
          // broken header
          send_line_byte(ifdr_pkg::FlagByte);
          send_line_byte(ifdr_pkg::AddrByte);
          if ($urandom_range(1)) send_line_byte(byte_t'($urandom_range(255)));
          else begin
            send_line_byte(ifdr_pkg::Ctrl0Byte);
            send_line_byte(byte_t'($urandom_range(255)));
          end
        end
      end
      wait_results_drained();
    end
  endtask

  // Main sequence
  initial begin
    rst_ni            <= 1'b0;
    line_if.valid     <= 1'b0;
    line_if.line_byte <= '0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    hold_request      = 0;
    line_words_sent   = 0;
    mismatch_count    = 0;
    reset_receiver_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_header_hunting();
    test_payload_destuffing();
    test_verdicts();
    test_length_limit();
    test_backpressure();
    test_random_frames();

    wait_results_drained();
    if (expected_words.size() != 0) begin
      $display("%0d expected words never arrived", expected_words.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
